// File: rtl/core/avr_pkg.sv
package avr_pkg;

  // CORDIC setup
  localparam int CORDIC_STEPS = 30;
  localparam int CW = 34;   // CORDIC x, y and z width
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW:0]   ONE_Q30 = 35'sd1073741824;

  // Arithmetic widths after the CORDIC
  localparam int PW = 72;   // product width
  localparam int RW = 48;   // rounded term width

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]        turn_angle;
  } avr_in_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } avr_out_t;

endpackage

// File: rtl/core/axis_angle_vector_rotate.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    avr_in_t  (vector, axis, angle)
// out_      output     out_valid/out_stall  avr_out_t (rotated vector)
//
// One transfer per cycle on each side while no result is stalled at the output.
// The path runs through the input register, the 30-stage CORDIC and 7 arithmetic stages.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers hold.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module axis_angle_vector_rotate (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  avr_pkg::avr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output avr_pkg::avr_out_t out_data
);
  import avr_pkg::*;

  logic en;

  // CORDIC stage registers: index 0 is the input stage
  logic                 cv_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0] cx_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0] cz_r   [CORDIC_STEPS+1];
  logic                 cf_r   [CORDIC_STEPS+1];
  avr_in_t              cd_r   [CORDIC_STEPS+1];

  logic [15:0] neg_ang;
  logic [31:0] ang32;

  // Advance when the output register is free or being taken
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Negate the angle and fold quadrants 1 and 2 by a half turn
  assign neg_ang = 16'(17'h10000 - {1'b0, in_data.turn_angle});
  assign ang32   = {neg_ang[15] ^ (neg_ang[15] ^ neg_ang[14]), neg_ang[14:0], 16'h0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= CORDIC_GAIN_Q30;
      cy_r[0] <= '0;
      cz_r[0] <= CW'($signed(ang32));
      cf_r[0] <= neg_ang[15] ^ neg_ang[14];
      cd_r[0] <= in_data;
    end
  end

  // One CORDIC rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] dx, dy, at;
    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;
    assign at = CW'(ATAN_TURNS[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (en) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          cz_r[i+1] <= cz_r[i] - at;
        end else begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          cz_r[i+1] <= cz_r[i] + at;
        end
        cf_r[i+1] <= cf_r[i];
        cd_r[i+1] <= cd_r[i];
      end
    end
  end

  // Post-CORDIC pipeline
  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic signed [CW-1:0] c1_r, s1_r, c2_r;
  avr_in_t              d1_r, d2_r;
  logic signed [RW-1:0] as_r [3];
  logic signed [RW-1:0] b_r  [3];
  logic signed [PW-1:0] xp_r [6];
  logic signed [PW-1:0] vb_r [3];
  logic signed [PW-1:0] vc_r [3];
  logic signed [15:0]   a3_r [3];
  logic signed [15:0]   a4_r [3];
  logic signed [15:0]   a5_r [3];
  logic signed [RW-1:0] t1_r [3];
  logic signed [RW-1:0] t2_r [3];
  logic signed [RW-1:0] db_r [3];
  logic signed [RW-1:0] t12_r  [3];
  logic signed [RW-1:0] t12b_r [3];
  logic signed [RW-1:0] dsum_r;
  logic signed [PW-1:0] ad_r [3];
  avr_out_t             out_r;

  logic signed [31:0] v2 [3];
  logic signed [15:0] a2 [3];
  logic signed [15:0] a1 [3];
  logic signed [CW:0] omc;

  assign v2[0] = d2_r.vec_x;  assign v2[1] = d2_r.vec_y;  assign v2[2] = d2_r.vec_z;
  assign a2[0] = d2_r.axis_x; assign a2[1] = d2_r.axis_y; assign a2[2] = d2_r.axis_z;
  assign a1[0] = d1_r.axis_x; assign a1[1] = d1_r.axis_y; assign a1[2] = d1_r.axis_z;
  assign omc   = ONE_Q30 - (CW+1)'(c1_r);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r} <= '0;
    end else if (en) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r} <=
        {cv_r[CORDIC_STEPS], v1_r, v2_r, v3_r, v4_r, v5_r, v6_r};
    end
  end

  // Stage 1: undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= cf_r[CORDIC_STEPS] ? -cx_r[CORDIC_STEPS] : cx_r[CORDIC_STEPS];
      s1_r <= cf_r[CORDIC_STEPS] ? -cy_r[CORDIC_STEPS] : cy_r[CORDIC_STEPS];
      d1_r <= cd_r[CORDIC_STEPS];
    end
  end

  // Stage 2: scaled axis terms a*s and a*(1-c)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        as_r[k] <= RW'((PW'(a1[k]) * PW'(s1_r) + PW'(33'sd32768)) >>> 16);
        b_r[k]  <= RW'((PW'(a1[k]) * PW'(omc) + PW'(33'sd32768)) >>> 16);
      end
      c2_r <= c1_r;
      d2_r <= d1_r;
    end
  end

  // Stage 3: cross, dot and cosine products
  always_ff @(posedge clk) begin
    if (en) begin
      xp_r[0] <= PW'(v2[1]) * PW'(as_r[2]);
      xp_r[1] <= PW'(v2[2]) * PW'(as_r[1]);
      xp_r[2] <= PW'(v2[2]) * PW'(as_r[0]);
      xp_r[3] <= PW'(v2[0]) * PW'(as_r[2]);
      xp_r[4] <= PW'(v2[0]) * PW'(as_r[1]);
      xp_r[5] <= PW'(v2[1]) * PW'(as_r[0]);
      for (int k = 0; k < 3; k++) begin
        vb_r[k] <= PW'(v2[k]) * PW'(b_r[k]);
        vc_r[k] <= PW'(v2[k]) * PW'(c2_r);
        a3_r[k] <= a2[k];
      end
    end
  end

  // Stage 4: round the products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t1_r[k] <= RW'((xp_r[2*k] - xp_r[2*k+1] + (PW'(1) <<< 27)) >>> 28);
        db_r[k] <= RW'((vb_r[k] + (PW'(1) <<< 27)) >>> 28);
        t2_r[k] <= RW'((vc_r[k] + (PW'(1) <<< 29)) >>> 30);
        a4_r[k] <= a3_r[k];
      end
    end
  end

  // Stage 5: dot product sum, and cross plus cosine terms
  always_ff @(posedge clk) begin
    if (en) begin
      dsum_r <= db_r[0] + db_r[1] + db_r[2];
      for (int k = 0; k < 3; k++) begin
        t12_r[k] <= t1_r[k] + t2_r[k];
        a5_r[k]  <= a4_r[k];
      end
    end
  end

  // Stage 6: axis times dot product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ad_r[k]   <= PW'(a5_r[k]) * PW'(dsum_r);
        t12b_r[k] <= t12_r[k];
      end
    end
  end

  // Stage 7: final sum and saturation
  logic signed [RW-1:0] res [3];
  logic signed [31:0]   sat [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res[k] = t12b_r[k] + RW'((ad_r[k] + (PW'(1) <<< 13)) >>> 14);
      if (res[k] > RW'(32'sh7FFFFFFF)) begin
        sat[k] = 32'sh7FFFFFFF;
      end else if (res[k] < RW'(-33'sh80000000)) begin
        sat[k] = 32'sh80000000;
      end else begin
        sat[k] = 32'(res[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.rot_x <= sat[0];
      out_r.rot_y <= sat[1];
      out_r.rot_z <= sat[2];
    end
  end

  assign out_valid = v7_r;
  assign out_data  = out_r;

endmodule

// File: tb/axis_angle_vector_rotate_tb.sv
`timescale 1ns / 1ps

module axis_angle_vector_rotate_tb;
  import avr_pkg::*;

  localparam int NUM_RANDOM = 2000;
  localparam int DRAIN_CYCLES = 60;

  // Q16.16 rotation predictor and queue of pending rotated vectors
  class rotation_scoreboard;
    avr_out_t pending_rot[$];
    int unsigned mismatches;

    function automatic longint floor_shr(longint x, int n);
      return x >>> n;
    endfunction

    function automatic longint round_shr(longint x, int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFFFFFF;
      if (x < -64'sd2147483648) return 32'h80000000;
      return x[31:0];
    endfunction

    // Sine and cosine in Q2.30 of a 16-bit binary angle
    function automatic void trig_q30(logic [15:0] ang, output longint sn, output longint cs);
      logic [31:0] a;
      logic flip;
      longint x, y, z, dx, dy;
      a = {ang, 16'h0000};
      flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
      x = 652032874;
      y = 0;
      if (flip) a = a - 32'h80000000;
      z = longint'(signed'(a));
      for (int i = 0; i < 30; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      cs = x;
      sn = y;
    endfunction

    function automatic avr_out_t rotate(avr_in_t it);
      longint v[3], ax[3], as[3], b[3], t1[3];
      longint sn, cs, omc, d, r;
      logic [31:0] res[3];
      avr_out_t o;
      v[0] = it.vec_x; v[1] = it.vec_y; v[2] = it.vec_z;
      ax[0] = it.axis_x; ax[1] = it.axis_y; ax[2] = it.axis_z;
      trig_q30(16'(17'h10000 - it.turn_angle), sn, cs);
      omc = 64'sd1073741824 - cs;
      for (int k = 0; k < 3; k++) begin
        as[k] = round_shr(ax[k] * sn, 16);
        b[k] = round_shr(ax[k] * omc, 16);
      end
      t1[0] = round_shr(v[1] * as[2] - v[2] * as[1], 28);
      t1[1] = round_shr(v[2] * as[0] - v[0] * as[2], 28);
      t1[2] = round_shr(v[0] * as[1] - v[1] * as[0], 28);
      d = 0;
      for (int k = 0; k < 3; k++) d += round_shr(v[k] * b[k], 28);
      for (int k = 0; k < 3; k++) begin
        r = t1[k] + round_shr(v[k] * cs, 30) + round_shr(ax[k] * d, 14);
        res[k] = clamp32(r);
      end
      o.rot_x = res[0]; o.rot_y = res[1]; o.rot_z = res[2];
      return o;
    endfunction

    function void note_input(avr_in_t it);
      pending_rot.push_back(rotate(it));
    endfunction

    function void check_result(avr_out_t got);
      avr_out_t exp_rot;
      if (pending_rot.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        mismatches++;
        return;
      end
      exp_rot = pending_rot.pop_front();
      if (got.rot_x !== exp_rot.rot_x) begin
        $display("%0t: rot_x expected %h actual %h", $realtime, exp_rot.rot_x, got.rot_x);
        mismatches++;
      end
      if (got.rot_y !== exp_rot.rot_y) begin
        $display("%0t: rot_y expected %h actual %h", $realtime, exp_rot.rot_y, got.rot_y);
        mismatches++;
      end
      if (got.rot_z !== exp_rot.rot_z) begin
        $display("%0t: rot_z expected %h actual %h", $realtime, exp_rot.rot_z, got.rot_z);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  avr_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  avr_out_t out_data;

  rotation_scoreboard board = new();
  avr_in_t vec_items[$];
  logic stall_mode = 1'b0;

  axis_angle_vector_rotate uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Note transfers on both sides
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_input(in_data);
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // Stall the result side in phases: light and heavy
  always @(posedge clk) begin
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) stall_mode <= ~stall_mode;
    if (!rst_n) out_stall <= 1'b0;
    else if (stall_mode) out_stall <= ($urandom_range(0, 99) < 60);
    else out_stall <= ($urandom_range(0, 99) < 8);
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 32768) - 16384);
      1: return 16'($urandom());
      2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($urandom_range(0, 23170) - 11585);
    endcase
  endfunction

  function automatic avr_in_t make_item(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                        logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                        logic [15:0] ang);
    avr_in_t it;
    it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
    it.axis_x = ax; it.axis_y = ay; it.axis_z = az;
    it.turn_angle = ang;
    return it;
  endfunction

  // Present one item and hold it until it transfers
  task automatic send_vector(avr_in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_all();
    int unsigned burst;
    while (vec_items.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && vec_items.size() > 0) begin
        send_vector(vec_items.pop_front());
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int unsigned waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero angle, quarter turns, extreme components, odd axes
    vec_items.push_back(make_item(32'h00010000, 32'h0, 32'h0, 16'h0, 16'h0, 16'd16384, 16'h0));
    vec_items.push_back(make_item(32'h00010000, 32'h0, 32'h0, 16'h0, 16'h0, 16'd16384, 16'h4000));
    vec_items.push_back(make_item(32'h00010000, 32'h0, 32'h0, 16'h0, 16'h0, 16'd16384, 16'h8000));
    vec_items.push_back(make_item(32'h00010000, 32'h0, 32'h0, 16'h0, 16'h0, 16'd16384, 16'hC000));
    vec_items.push_back(make_item(32'h0, 32'h00030000, 32'hFFFE0000,
                                  16'd16384, 16'h0, 16'h0, 16'hFFFF));
    vec_items.push_back(make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  16'h8000, 16'h8000, 16'h8000, 16'h6000));
    vec_items.push_back(make_item(32'h80000000, 32'h80000000, 32'h80000000,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hA000));
    vec_items.push_back(make_item(32'h7FFFFFFF, 32'h80000000, 32'h0,
                                  -16'sd16384, 16'd16384, -16'sd16384, 16'h0001));
    vec_items.push_back(make_item(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                                  16'h0, -16'sd16384, 16'h0, 16'h8001));
    vec_items.push_back(make_item(32'h12345678, 32'hEDCBA987, 32'h00000001,
                                  16'd9459, 16'd9459, 16'd9459, 16'h7FFF));
    vec_items.push_back(make_item(32'h0, 32'h0, 32'h0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h3FFF));
    vec_items.push_back(make_item(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                                  16'h5555, 16'hAAAA, 16'h0001, 16'hC001));
    vec_items.push_back(make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0,
                                  16'h0, 16'h0, 16'h0, 16'h2000));
    // Random vectors and axes
    repeat (NUM_RANDOM)
      vec_items.push_back(make_item(rand_comp(), rand_comp(), rand_comp(),
                                    rand_axis(), rand_axis(), rand_axis(), 16'($urandom())));
    send_all();

    // Drain outstanding results, then let the pipeline settle
    waited = 0;
    while (board.pending_rot.size() > 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_rot.size() == 0)
      $display("** axis_angle_vector_rotate: PASSED **");
    else
      $display("** axis_angle_vector_rotate: FAILED **");
    $finish;
  end

  // Hard limit on run length
  initial begin
    #5ms;
    $display("** axis_angle_vector_rotate: FAILED **");
    $finish;
  end

endmodule

// File: files.f
rtl/core/avr_pkg.sv
rtl/core/axis_angle_vector_rotate.sv
tb/axis_angle_vector_rotate_tb.sv
